@@ design/mdss_pkg.sv @@
`default_nettype none
package mdss_pkg;

  localparam int unsigned NUM_STATES = 19;

  typedef enum logic [4:0] {
    ST_ICLWAIT               = 5'd0,
    ST_IDLE                  = 5'd1,
    ST_IDLE_ALIGNMENT        = 5'd2,
    ST_ALIGN_CHARGE_BOOT_CAP = 5'd3,
    ST_ALIGN_OFFSET_CALIB    = 5'd4,
    ST_ALIGN_CLEAR           = 5'd5,
    ST_ALIGNMENT             = 5'd6,
    ST_IDLE_READY            = 5'd7,
    ST_CHARGE_BOOT_CAP       = 5'd8,
    ST_OFFSET_CALIB          = 5'd9,
    ST_CLEAR                 = 5'd10,
    ST_START                 = 5'd11,
    ST_START_RUN             = 5'd12,
    ST_RUN                   = 5'd13,
    ST_ANY_STOP              = 5'd14,
    ST_STOP                  = 5'd15,
    ST_STOP_IDLE             = 5'd16,
    ST_FAULT_ACTIVE          = 5'd17,
    ST_FAULT_OVER            = 5'd18
  } mode_t;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_REQUEST = 2'd1,
    OP_FAULT   = 2'd2,
    OP_ACK     = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_START_STATE  = 1'b0,
    REG_SW_ERROR_BIT = 1'b1
  } reg_idx_t;

  localparam logic [4:0]  START_STATE_RESET = 5'd7;
  localparam logic [15:0] SW_ERROR_RESET    = 16'd128;

  typedef struct packed {
    op_t         func;
    logic [4:0]  requested_state;
    logic [15:0] set_errors;
    logic [15:0] reset_errors;
  } req_t;

  typedef struct packed {
    logic [4:0]  current_state;
    logic        changed;
    logic        acknowledged;
    logic [15:0] faults_present;
    logic [15:0] faults_seen;
  } rsp_t;

  typedef struct packed {
    logic [4:0]  start_state;
    logic [15:0] sw_error_bit;
  } cfg_t;

  function automatic logic [NUM_STATES-1:0] allowed_next(input mode_t m);
    logic [NUM_STATES-1:0] a;
    a = '0;
    case (m)
      ST_ICLWAIT:               a[ST_IDLE] = 1'b1;
      ST_IDLE: begin
        a[ST_IDLE_READY] = 1'b1;
        a[ST_IDLE_ALIGNMENT] = 1'b1;
        a[ST_ICLWAIT] = 1'b1;
      end
      ST_IDLE_ALIGNMENT: begin
        a[ST_ANY_STOP] = 1'b1;
        a[ST_ALIGN_CHARGE_BOOT_CAP] = 1'b1;
        a[ST_ALIGN_OFFSET_CALIB] = 1'b1;
      end
      ST_ALIGN_CHARGE_BOOT_CAP: begin
        a[ST_ALIGN_OFFSET_CALIB] = 1'b1;
        a[ST_ANY_STOP] = 1'b1;
      end
      ST_ALIGN_OFFSET_CALIB: begin
        a[ST_ALIGN_CLEAR] = 1'b1;
        a[ST_ANY_STOP] = 1'b1;
      end
      ST_ALIGN_CLEAR: begin
        a[ST_ALIGNMENT] = 1'b1;
        a[ST_ANY_STOP] = 1'b1;
      end
      ST_ALIGNMENT:             a[ST_ANY_STOP] = 1'b1;
      ST_IDLE_READY: begin
        a[ST_ANY_STOP] = 1'b1;
        a[ST_CHARGE_BOOT_CAP] = 1'b1;
        a[ST_START] = 1'b1;
        a[ST_OFFSET_CALIB] = 1'b1;
        a[ST_IDLE_ALIGNMENT] = 1'b1;
      end
      ST_CHARGE_BOOT_CAP: begin
        a[ST_OFFSET_CALIB] = 1'b1;
        a[ST_ANY_STOP] = 1'b1;
      end
      ST_OFFSET_CALIB: begin
        a[ST_CLEAR] = 1'b1;
        a[ST_ANY_STOP] = 1'b1;
      end
      ST_CLEAR: begin
        a[ST_START] = 1'b1;
        a[ST_ANY_STOP] = 1'b1;
      end
      ST_START: begin
        a[ST_START_RUN] = 1'b1;
        a[ST_ANY_STOP] = 1'b1;
      end
      ST_START_RUN: begin
        a[ST_RUN] = 1'b1;
        a[ST_ANY_STOP] = 1'b1;
      end
      ST_RUN:                   a[ST_ANY_STOP] = 1'b1;
      ST_ANY_STOP:              a[ST_STOP] = 1'b1;
      ST_STOP:                  a[ST_STOP_IDLE] = 1'b1;
      ST_STOP_IDLE: begin
        a[ST_IDLE] = 1'b1;
        a[ST_ICLWAIT] = 1'b1;
      end
      default:                  a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ design/motor_drive_state_sequencer.sv @@
// a request word is held in the input register, and its response word is registered in the response register
// one word per cycle while rsp_ready does not stall the output; input register, state update and response register
// the mode and fault words update as a word leaves the input register
// reset (synchronous, active high): mode IDLE_READY, both fault words zero,
// start_state 7, sw_error_bit 0x0080, both stages empty
`default_nettype none
module motor_drive_state_sequencer (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire mdss_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output mdss_pkg::rsp_t      rsp,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  mdss_pkg::cfg_t cfg;
  mdss_pkg::req_t word;
  mdss_pkg::rsp_t result;
  logic           word_valid;
  logic           fire;

  assign fire      = word_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !word_valid || fire;

  mdss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mdss_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .word   (word),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (req_ready) begin
      word_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      word <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || rsp_ready) begin
      rsp_valid <= word_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= result;
    end
  end

endmodule
`default_nettype wire

@@ design/mdss_cfg.sv @@
`default_nettype none
module mdss_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output mdss_pkg::cfg_t         cfg
);

  logic             wr_en;
  mdss_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = mdss_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_state  <= mdss_pkg::START_STATE_RESET;
      cfg.sw_error_bit <= mdss_pkg::SW_ERROR_RESET;
    end else if (wr_en) begin
      case (idx)
        mdss_pkg::REG_START_STATE:  cfg.start_state  <= pwdata[4:0];
        mdss_pkg::REG_SW_ERROR_BIT: cfg.sw_error_bit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mdss_pkg::REG_START_STATE:  prdata = {27'd0, cfg.start_state};
      mdss_pkg::REG_SW_ERROR_BIT: prdata = {16'd0, cfg.sw_error_bit};
      default:                    prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ design/mdss_core.sv @@
`default_nettype none
module mdss_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mdss_pkg::cfg_t cfg,
  input  wire logic           fire,
  input  wire mdss_pkg::req_t word,
  output mdss_pkg::rsp_t      result
);

  mdss_pkg::mode_t mode, mode_next;
  logic [15:0]     fault_cur, fault_cur_next;
  logic [15:0]     fault_hist, fault_hist_next;
  logic [mdss_pkg::NUM_STATES-1:0] allowed;
  logic            req_ok;
  logic            apply;
  logic [15:0]     set_m, clr_m;
  logic            changed, acked;
  mdss_pkg::mode_t mode_mid;
  logic [15:0]     now_mid, hist_mid;

  assign allowed = mdss_pkg::allowed_next(mode);
  assign req_ok  = (word.requested_state < 5'(mdss_pkg::NUM_STATES))
                   && allowed[word.requested_state];

  always_comb begin
    mode_mid = mode;
    now_mid  = fault_cur;
    hist_mid = fault_hist;
    changed  = 1'b0;
    acked    = 1'b0;
    apply    = 1'b0;
    set_m    = '0;
    clr_m    = '0;
    case (word.func)
      mdss_pkg::OP_INIT: begin
        mode_mid = (cfg.start_state < 5'(mdss_pkg::NUM_STATES))
                   ? mdss_pkg::mode_t'(cfg.start_state) : mdss_pkg::ST_IDLE_READY;
        now_mid  = '0;
        hist_mid = '0;
      end
      mdss_pkg::OP_REQUEST: begin
        if (req_ok) begin
          mode_mid = mdss_pkg::mode_t'(word.requested_state);
          changed  = 1'b1;
        end else if (!(word.requested_state inside {mdss_pkg::ST_IDLE_READY,
                       mdss_pkg::ST_IDLE_ALIGNMENT, mdss_pkg::ST_ANY_STOP})) begin
          apply = 1'b1;
          set_m = cfg.sw_error_bit;
        end
      end
      mdss_pkg::OP_FAULT: begin
        apply = 1'b1;
        set_m = word.set_errors;
        clr_m = word.reset_errors;
      end
      mdss_pkg::OP_ACK: begin
        if (mode == mdss_pkg::ST_FAULT_OVER) begin
          mode_mid = mdss_pkg::ST_STOP_IDLE;
          hist_mid = '0;
          acked    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    mode_next       = mode_mid;
    fault_cur_next  = now_mid;
    fault_hist_next = hist_mid;
    if (apply) begin
      fault_cur_next  = (fault_cur | set_m) & ~clr_m;
      fault_hist_next = fault_hist | set_m;
      if (mode == mdss_pkg::ST_FAULT_ACTIVE) begin
        if (fault_cur_next == '0) mode_next = mdss_pkg::ST_FAULT_OVER;
      end else if (fault_cur_next != '0) begin
        mode_next = mdss_pkg::ST_FAULT_ACTIVE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= mdss_pkg::ST_IDLE_READY;
      fault_cur  <= '0;
      fault_hist <= '0;
    end else if (fire) begin
      mode       <= mode_next;
      fault_cur  <= fault_cur_next;
      fault_hist <= fault_hist_next;
    end
  end

  assign result.current_state  = mode_next;
  assign result.changed        = changed;
  assign result.acknowledged   = acked;
  assign result.faults_present = fault_cur_next;
  assign result.faults_seen    = fault_hist_next;

endmodule
`default_nettype wire

@@ design/mdss_checker.sv @@
`default_nettype none
module mdss_checker (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           rsp_valid,
  input  wire logic           rsp_ready,
  input  wire mdss_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response word changed while stalled");

  a_state_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.current_state < 5'(mdss_pkg::NUM_STATES))
    else $error("state code out of range");

  a_ack_effect: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.acknowledged |->
      rsp.current_state == mdss_pkg::ST_STOP_IDLE && rsp.faults_seen == 16'd0
      && !rsp.changed)
    else $error("acknowledge result inconsistent");

  a_present_in_seen: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.current_state != mdss_pkg::ST_FAULT_ACTIVE
      && rsp.current_state != mdss_pkg::ST_FAULT_OVER |-> rsp.faults_present == 16'd0)
    else $error("faults present outside a fault state");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind motor_drive_state_sequencer mdss_checker u_mdss_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
`default_nettype wire
